[hw/rtl/dpca_pkg.sv]
// Shared types, constants and helpers for the drum pad choke arbiter.
// Used by dpca_cell and drum_pad_choke_arbiter; depends on nothing else.

package dpca_pkg;

    localparam int PADS      = 16;
    localparam int PAD_W     = $clog2(PADS);
    localparam int NOTES     = 128;
    localparam int NOTE_W    = $clog2(NOTES);
    localparam int BASE_NOTE = 36;
    localparam int VEL_W     = 7;
    localparam int GRP_W     = 4;
    localparam int BLK_W     = 32;
    localparam int WIN_W     = 8;
    localparam int ENT_W     = PAD_W + 1;

    // Configuration register indexes.
    localparam logic CFG_AUTO_SELECT = 1'b0;
    localparam logic CFG_LIVE_WINDOW = 1'b1;

    typedef enum logic [2:0] {
        CMD_NOTE_ON    = 3'd0,
        CMD_NOTE_OFF   = 3'd1,
        CMD_BLOCK_TICK = 3'd2,
        CMD_MAP_NOTE   = 3'd3,
        CMD_SET_GROUP  = 3'd4,
        CMD_VOICE_DONE = 3'd5,
        CMD_ALL_OFF    = 3'd6,
        CMD_LIVE_ARM   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_CHOKE   = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_LOST    = 3'd3,
        ACT_DONE    = 3'd4,
        ACT_IGNORED = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WALK,
        S_START,
        S_DONE,
        S_MAP_CHECK,
        S_MAP_SET
    } t_state;

    // Query that travels down the row of pad cells during a note-on.
    typedef struct packed {
        logic              valid;
        logic [PAD_W-1:0]  pad;
        logic [GRP_W-1:0]  grp;
        logic [NOTE_W-1:0] note;
    } t_walk_pkt;

    // What a cell decides about the query it currently holds.
    typedef struct packed {
        logic             hit;
        logic             lose;
        logic [PAD_W-1:0] pad;
    } t_verdict;

    // State updates broadcast to all cells; each cell matches pad to its index, but all_off clears every cell.
    typedef struct packed {
        logic              set_group;
        logic              clear_voice;
        logic              all_off;
        logic              start_voice;
        logic              set_note;
        logic [PAD_W-1:0]  pad;
        logic [GRP_W-1:0]  grp;
        logic [NOTE_W-1:0] note;
        logic [BLK_W-1:0]  blk;
    } t_cell_ctl;

    typedef struct packed {
        logic             valid;
        logic [PAD_W-1:0] pad;
    } t_map_entry;

    // Note map contents after reset: the pad row starts at the base note.
    function automatic t_map_entry f_reset_entry(input logic [NOTE_W-1:0] note);
        logic [NOTE_W:0] rel;
        t_map_entry      e;
        rel     = {1'b0, note} - (NOTE_W+1)'(BASE_NOTE);
        e.valid = ({1'b0, note} >= (NOTE_W+1)'(BASE_NOTE)) &&
                  (rel < (NOTE_W+1)'(PADS));
        e.pad   = rel[PAD_W-1:0];
        return e;
    endfunction

endpackage

[hw/rtl/dpca_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.

module dpca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/dpca_cell.sv]
// One pad cell: holds the pad's note, group and voice, and checks the walk query.
// Depends on dpca_pkg.

module dpca_cell import dpca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PAD_W-1:0]  i_idx,
    input  logic              i_adv,
    input  t_walk_pkt         i_pkt,
    output t_walk_pkt         o_pkt,
    output t_verdict          o_verdict,
    output logic              o_busy,
    input  t_cell_ctl         i_ctl,
    input  logic [BLK_W-1:0]  i_block,
    output logic [NOTE_W-1:0] o_pad_note,
    output logic [GRP_W-1:0]  o_group
);

    t_walk_pkt         r_pkt;
    logic [NOTE_W-1:0] r_pad_note;
    logic [GRP_W-1:0]  r_group;
    logic              r_active;
    logic [NOTE_W-1:0] r_vnote;
    logic [BLK_W-1:0]  r_vblock;

    logic sel;
    logic hit;
    logic lose;

    assign sel  = (i_ctl.pad == i_idx);
    assign hit  = r_pkt.valid && (r_pkt.pad != i_idx) && (r_group == r_pkt.grp) && r_active;
    // A voice started in this block with a higher note wins over the new one.
    assign lose = hit && (r_vblock == i_block) && (r_vnote > r_pkt.note);

    always_comb begin
        o_pkt       = r_pkt;
        o_pkt.valid = r_pkt.valid && !lose;
    end

    assign o_verdict.hit  = hit;
    assign o_verdict.lose = lose;
    assign o_verdict.pad  = i_idx;
    assign o_busy         = r_pkt.valid;
    assign o_pad_note     = r_pad_note;
    assign o_group        = r_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt      <= '0;
            r_pad_note <= NOTE_W'(BASE_NOTE) + NOTE_W'(i_idx);
            r_group    <= '0;
            r_active   <= 1'b0;
            r_vnote    <= '0;
            r_vblock   <= '0;
        end else begin
            if (i_adv) begin
                r_pkt <= i_pkt;
            end
            if (i_ctl.set_group && sel) begin
                r_group <= i_ctl.grp;
            end
            if (i_ctl.set_note && sel) begin
                r_pad_note <= i_ctl.note;
            end
            if (i_ctl.all_off) begin
                r_active <= 1'b0;
            end else if (i_ctl.clear_voice && sel) begin
                r_active <= 1'b0;
            end else if (i_ctl.start_voice && sel) begin
                r_active <= 1'b1;
                r_vnote  <= i_ctl.note;
                r_vblock <= i_ctl.blk;
            end
        end
    end

endmodule

[hw/rtl/drum_pad_choke_arbiter.sv]
// Top level of the drum pad choke arbiter: control, note map RAM and the pad cell row.
// Depends on dpca_pkg, dpca_ram and dpca_cell.
//
//   channel   valid        ready        payload
//   input     i_in_valid   o_in_ready   i_command i_pad i_note i_velocity i_group
//                                       i_transport_running i_host_vouches
//   output    o_out_valid  i_out_ready  o_action o_out_pad o_out_note o_out_velocity
//                                       o_focus_pad o_last
//   config    i_cfg_valid  o_cfg_ready  i_cfg_index i_cfg_data
//
// One item at a time. A note-on of a grouped pad passes the accept, a note map read,
// then each pad cell in turn as the query moves down the row, then the start item, or it
// ends early with a lost item. An ungrouped note-on skips the walk; map_note does a check
// step and a set step. A stalled output holds the walk in place. Reset is synchronous; no
// clearing pass.

module drum_pad_choke_arbiter import dpca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_command,
    input  logic [3:0]        i_pad,
    input  logic [NOTE_W-1:0] i_note,
    input  logic [VEL_W-1:0]  i_velocity,
    input  logic [GRP_W-1:0]  i_group,
    input  logic              i_transport_running,
    input  logic              i_host_vouches,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_action,
    output logic [3:0]        o_out_pad,
    output logic [NOTE_W-1:0] o_out_note,
    output logic [VEL_W-1:0]  o_out_velocity,
    output logic [3:0]        o_focus_pad,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [WIN_W-1:0]  i_cfg_data
);

    t_state            r_state, n_state;
    logic              r_auto;
    logic [WIN_W-1:0]  r_window;
    logic [BLK_W-1:0]  r_block, n_block;
    logic [PAD_W-1:0]  r_focus, n_focus;
    logic              r_armed, n_armed;
    logic [BLK_W-1:0]  r_arm_block, n_arm_block;
    logic [NOTES-1:0]  r_written;

    logic              r_is_on;
    logic [PAD_W-1:0]  r_pad;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic              r_running;
    logic              r_vouch;
    logic [NOTE_W-1:0] r_lk_addr;
    logic              r_lk_written;
    logic [PAD_W-1:0]  r_p, n_p;

    logic              r_out_valid;
    t_action           r_out_act;
    logic [PAD_W-1:0]  r_out_pad;
    logic [NOTE_W-1:0] r_out_note;
    logic [VEL_W-1:0]  r_out_vel;
    logic [PAD_W-1:0]  r_out_focus;
    logic              r_out_last;

    logic              in_acc;
    logic              slot_free;
    logic              ld;
    t_action           ld_act;
    logic [PAD_W-1:0]  ld_pad;
    logic [NOTE_W-1:0] ld_note;
    logic [VEL_W-1:0]  ld_vel;
    logic              ld_last;

    logic              ram_we;
    logic [NOTE_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [NOTE_W-1:0] ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    t_map_entry        ent;

    t_cell_ctl         ctl;
    logic              launch;
    t_walk_pkt         launch_pkt;
    logic              adv;
    t_walk_pkt         w_pkt [PADS+1];
    t_verdict          w_verdict [PADS];
    logic [PADS-1:0]   w_busy;
    logic [NOTE_W-1:0] w_pad_note [PADS];
    logic [GRP_W-1:0]  w_group [PADS];

    logic              vd_hit;
    logic              vd_lose;
    logic [PAD_W-1:0]  vd_pad;
    logic [BLK_W-1:0]  arm_age;
    logic              take_focus;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign adv         = launch || ((r_state == S_WALK) && slot_free);
    // Entries never written since reset read as the reset mapping.
    assign ent         = r_lk_written ? t_map_entry'(ram_rdata) : f_reset_entry(r_lk_addr);
    assign arm_age     = r_block - r_arm_block;
    assign w_pkt[0]    = launch_pkt;

    dpca_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NOTES)
    ) u_note_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    genvar g;
    for (g = 0; g < PADS; g++) begin : g_cell
        dpca_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (PAD_W'(g)),
            .i_adv      (adv),
            .i_pkt      (w_pkt[g]),
            .o_pkt      (w_pkt[g+1]),
            .o_verdict  (w_verdict[g]),
            .o_busy     (w_busy[g]),
            .i_ctl      (ctl),
            .i_block    (r_block),
            .o_pad_note (w_pad_note[g]),
            .o_group    (w_group[g])
        );
    end

    // Only one cell holds the query, so its verdict can be gathered by OR.
    always_comb begin
        vd_hit  = 1'b0;
        vd_lose = 1'b0;
        vd_pad  = '0;
        for (int i = 0; i < PADS; i++) begin
            vd_hit  = vd_hit | w_verdict[i].hit;
            vd_lose = vd_lose | w_verdict[i].lose;
            vd_pad  = vd_pad | (w_verdict[i].hit ? w_verdict[i].pad : '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_block     = r_block;
        n_focus     = r_focus;
        n_armed     = r_armed;
        n_arm_block = r_arm_block;
        n_p         = r_p;
        ld          = 1'b0;
        ld_act      = ACT_IGNORED;
        ld_pad      = '0;
        ld_note     = '0;
        ld_vel      = '0;
        ld_last     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_note;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = i_note;
        ctl         = '0;
        launch      = 1'b0;
        take_focus  = 1'b0;
        launch_pkt  = '0;

        case (r_state)
            S_IDLE: begin
                ctl.pad = i_pad[PAD_W-1:0];
                ctl.grp = i_group;
                if (in_acc) begin
                    case (t_cmd'(i_command))
                        CMD_NOTE_ON, CMD_NOTE_OFF: begin
                            ram_re  = 1'b1;
                            n_state = S_LOOKUP;
                        end
                        CMD_BLOCK_TICK: begin
                            n_block = r_block + BLK_W'(1);
                        end
                        CMD_MAP_NOTE: begin
                            ram_re    = 1'b1;
                            ram_raddr = w_pad_note[i_pad[PAD_W-1:0]];
                            n_state   = S_MAP_CHECK;
                        end
                        CMD_SET_GROUP: begin
                            ctl.set_group = 1'b1;
                        end
                        CMD_VOICE_DONE: begin
                            ctl.clear_voice = 1'b1;
                            n_state         = S_DONE;
                        end
                        CMD_ALL_OFF: begin
                            ctl.all_off = 1'b1;
                        end
                        CMD_LIVE_ARM: begin
                            n_armed     = 1'b1;
                            n_arm_block = r_block;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOKUP: begin
                if (!r_is_on || !ent.valid) begin
                    if (slot_free) begin
                        ld      = 1'b1;
                        ld_act  = ent.valid ? ACT_RELEASE : ACT_IGNORED;
                        ld_pad  = ent.valid ? ent.pad : '0;
                        ld_note = r_note;
                        ld_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_p = ent.pad;
                    take_focus = r_auto && ((!r_running && !r_vouch) ||
                                 (r_armed && (arm_age <= BLK_W'(r_window))));
                    if (take_focus) begin
                        n_focus = ent.pad;
                        n_armed = 1'b0;
                    end
                    if (w_group[ent.pad] != '0) begin
                        launch           = 1'b1;
                        launch_pkt.valid = 1'b1;
                        launch_pkt.pad   = ent.pad;
                        launch_pkt.grp   = w_group[ent.pad];
                        launch_pkt.note  = r_note;
                        n_state          = S_WALK;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_WALK: begin
                if (slot_free) begin
                    if (vd_hit) begin
                        ld      = 1'b1;
                        ld_act  = vd_lose ? ACT_LOST : ACT_CHOKE;
                        ld_pad  = vd_lose ? r_p : vd_pad;
                        ld_note = vd_lose ? r_note : '0;
                        ld_last = vd_lose;
                        if (vd_lose) begin
                            n_state = S_IDLE;
                        end
                    end
                    if (w_pkt[PADS].valid) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (slot_free) begin
                    ld              = 1'b1;
                    ld_act          = ACT_START;
                    ld_pad          = r_p;
                    ld_note         = r_note;
                    ld_vel          = r_vel;
                    ld_last         = 1'b1;
                    ctl.start_voice = 1'b1;
                    ctl.pad         = r_p;
                    ctl.note        = r_note;
                    ctl.blk         = r_block;
                    n_state         = S_IDLE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_act  = ACT_DONE;
                    ld_pad  = r_pad;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MAP_CHECK: begin
                // Drop the old note only if it still points at this pad.
                if (ent.valid && (ent.pad == r_pad)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lk_addr;
                    ram_wdata = {1'b0, r_pad};
                end
                n_state = S_MAP_SET;
            end
            S_MAP_SET: begin
                ram_we       = 1'b1;
                ram_waddr    = r_note;
                ram_wdata    = {1'b1, r_pad};
                ctl.set_note = 1'b1;
                ctl.pad      = r_pad;
                ctl.note     = r_note;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_auto      <= 1'b1;
            r_window    <= WIN_W'(4);
            r_block     <= '0;
            r_focus     <= '0;
            r_armed     <= 1'b0;
            r_arm_block <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_block     <= n_block;
            r_focus     <= n_focus;
            r_armed     <= n_armed;
            r_arm_block <= n_arm_block;
            if (ram_we) begin
                r_written[ram_waddr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AUTO_SELECT: r_auto   <= i_cfg_data[0];
                    CFG_LIVE_WINDOW: r_window <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (in_acc) begin
            r_is_on      <= (t_cmd'(i_command) == CMD_NOTE_ON);
            r_pad        <= i_pad[PAD_W-1:0];
            r_note       <= i_note;
            r_vel        <= i_velocity;
            r_running    <= i_transport_running;
            r_vouch      <= i_host_vouches;
            r_lk_addr    <= ram_raddr;
            r_lk_written <= r_written[ram_raddr];
        end
        if (ld) begin
            r_out_act   <= ld_act;
            r_out_pad   <= ld_pad;
            r_out_note  <= ld_note;
            r_out_vel   <= ld_vel;
            r_out_focus <= r_focus;
            r_out_last  <= ld_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_out_act;
    assign o_out_pad      = 4'(r_out_pad);
    assign o_out_note     = r_out_note;
    assign o_out_velocity = r_out_vel;
    assign o_focus_pad    = 4'(r_out_focus);
    assign o_last         = r_out_last;

    // The query sits in at most one cell at a time.
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_busy))
        else $error("more than one cell holds the walk query");

    // Outside a walk the cell row is empty.
    a_row_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |-> (w_busy == '0))
        else $error("walk query left in the cell row");

    // A launch puts the query into the first cell.
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |=> ((r_state == S_WALK) && w_busy[0]))
        else $error("launched query did not reach the first cell");

    // A remap always leaves the new note marked as written.
    a_map_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP_SET) |=> r_written[$past(r_note)])
        else $error("remapped note not marked as written");

endmodule
